[rtl/h2d_pkg.sv]
// shared types and constants of the http/2 frame deframer
`timescale 1ns / 1ps
`default_nettype none
package h2d_pkg;

  localparam int unsigned LenW = 24;
  localparam int unsigned SidW = 31;
  localparam logic [LenW-1:0] MaxPayloadReset = 24'd16384;
  // header bytes gathered before the ninth byte completes the header
  localparam logic [3:0] HdrGather = 4'd8;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_ERROR   = 2'd2
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [LenW-1:0] max_payload;
  } cfg_item_t;

  typedef struct packed {
    kind_e           kind;
    logic [LenW-1:0] frame_length;
    logic [7:0]      frame_type;
    logic [7:0]      frame_flags;
    logic [SidW-1:0] strm_id;
    logic [7:0]      payload_byte;
    logic            last_of_frame;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_t;

endpackage
`default_nettype wire

[rtl/h2d_chan_if.sv]
// valid/ready channel carrying one payload per transaction
`timescale 1ns / 1ps
`default_nettype none
interface h2d_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[rtl/h2d_parser.sv]
// frame header parser state and per-byte result logic
`timescale 1ns / 1ps
`default_nettype none
module h2d_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               byte_valid_i,
  input  h2d_pkg::in_item_t  byte_i,
  input  logic               cfg_valid_i,
  input  h2d_pkg::cfg_item_t cfg_i,
  output h2d_pkg::res_t      res_o
);
  import h2d_pkg::*;

  logic [LenW-1:0] max_q, max_d;
  logic [63:0]     hdr_q, hdr_d;
  logic [3:0]      cnt_q, cnt_d;
  logic [LenW-1:0] left_q, left_d;
  phase_e          phase_q, phase_d;

  logic [LenW-1:0] len;
  logic [LenW-1:0] left_dec;

  assign len      = hdr_q[63:40];
  assign left_dec = (left_q != '0) ? left_q - LenW'(1) : '0;

  always_comb begin
    max_d   = cfg_valid_i ? cfg_i.max_payload : max_q;
    hdr_d   = hdr_q;
    cnt_d   = cnt_q;
    left_d  = left_q;
    phase_d = phase_q;
    res_o   = '0;
    if (byte_valid_i) begin
      unique case (phase_q)
        PH_HEADER: begin
          if (cnt_q < HdrGather) begin
            hdr_d = {hdr_q[55:0], byte_i.data_byte};
            cnt_d = cnt_q + 4'd1;
          end else begin
            hdr_d                   = '0;
            cnt_d                   = '0;
            res_o.valid             = 1'b1;
            res_o.item.frame_length = len;
            res_o.item.frame_type   = hdr_q[39:32];
            res_o.item.frame_flags  = hdr_q[31:24];
            res_o.item.strm_id      = {hdr_q[22:16], hdr_q[15:8], hdr_q[7:0],
                                       byte_i.data_byte};
            if (len > max_q) begin
              phase_d                  = PH_ERROR;
              left_d                   = '0;
              res_o.item.kind          = KIND_ERROR;
              res_o.item.last_of_frame = 1'b1;
            end else begin
              left_d                   = len;
              phase_d                  = (len == '0) ? PH_HEADER : PH_PAYLOAD;
              res_o.item.kind          = KIND_HEADER;
              res_o.item.last_of_frame = (len == '0);
            end
          end
        end
        PH_PAYLOAD: begin
          left_d                   = left_dec;
          res_o.valid              = 1'b1;
          res_o.item.kind          = KIND_PAYLOAD;
          res_o.item.payload_byte  = byte_i.data_byte;
          res_o.item.last_of_frame = (left_dec == '0);
          if (left_dec == '0) begin
            phase_d = PH_HEADER;
          end
        end
        default: begin
          // sticky error: bytes are dropped
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q   <= MaxPayloadReset;
      hdr_q   <= '0;
      cnt_q   <= '0;
      left_q  <= '0;
      phase_q <= PH_HEADER;
    end else begin
      max_q   <= max_d;
      hdr_q   <= hdr_d;
      cnt_q   <= cnt_d;
      left_q  <= left_d;
      phase_q <= phase_d;
    end
  end

endmodule
`default_nettype wire

[rtl/http2_frame_deframer_top.sv]
// top level of the http/2 frame deframer
// Takes one stream byte per transaction and can accept a byte in every cycle
// while the result side keeps up: each byte is parsed in the cycle it is
// taken and any result (header, payload byte or oversize error) appears in the
// output register on the next cycle. The output register frees itself in the
// cycle its result is taken, so a stalled result side stops input only while
// it holds that register. After an oversize error every byte is accepted and
// dropped until reset. max_payload may be written at any time the block is
// idle and applies from the next header check.
`timescale 1ns / 1ps
`default_nettype none
module http2_frame_deframer_top (
  input logic       clk_i,
  input logic       rst_ni,
  h2d_chan_if.sink   in_i,
  h2d_chan_if.sink   cfg_i,
  h2d_chan_if.source out_o
);
  import h2d_pkg::*;

  logic      in_accept;
  res_t      res;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign cfg_i.ready = 1'b1;
  assign in_accept   = in_i.valid && in_i.ready;

  h2d_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (in_accept),
    .byte_i       (in_i.payload),
    .cfg_valid_i  (cfg_i.valid),
    .cfg_i        (cfg_i.payload),
    .res_o        (res)
  );

  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    out_d       = out_q;
    if (res.valid) begin
      out_valid_d = 1'b1;
      out_d       = res.item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |=> out_valid_q)
    else $error("parser result not registered");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind == KIND_ERROR |-> out_q.last_of_frame)
    else $error("error result not marked last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind == KIND_PAYLOAD
      |-> out_q.frame_length == '0 && out_q.strm_id == '0)
    else $error("payload result carries header fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> in_accept)
    else $error("result without an accepted byte");

endmodule
`default_nettype wire
